@@ design/chj_pkg.sv @@
// ----------------------------------------------------------------------------
// chj_pkg: shared types and constants for the chained hash-join table
// Sizes, request and result layouts, status and opcode codes, and the
// control structs passed between the sequencer and its stores.
// ----------------------------------------------------------------------------
`default_nettype none

package chj_pkg;

    localparam int BUCKET_BITS  = 6;
    localparam int CAPACITY     = 64;
    localparam int PAYLOAD_BITS = 64;

    localparam int NBUCKETS  = 1 << BUCKET_BITS;
    localparam int IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int LINK_W    = 7;
    localparam int KEY_W     = 32;
    localparam int IN_PAY_W  = 64;
    localparam int OUT_PAY_W = 64;

    localparam logic [LINK_W-1:0] END_MARK = {LINK_W{1'b1}};
    localparam logic [LINK_W-1:0] CAP_LINK = LINK_W'(CAPACITY);

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_INSERT = 2'd1,
        OP_PROBE  = 2'd2
    } opcode_t;

    typedef enum logic [2:0] {
        ST_CLEARED  = 3'd0,
        ST_INSERTED = 3'd1,
        ST_FULL     = 3'd2,
        ST_MATCH    = 3'd3,
        ST_NOMATCH  = 3'd4
    } status_t;

    typedef struct packed {
        opcode_t              opcode;
        logic [KEY_W-1:0]     key;
        logic [IN_PAY_W-1:0]  payload;
    } chj_in_t;

    typedef struct packed {
        status_t              status;
        logic [OUT_PAY_W-1:0] match_payload;
        logic [KEY_W-1:0]     match_key;
        logic                 last;
    } chj_out_t;

    // Bucket head store control
    typedef struct packed {
        logic                   clear;
        logic                   wr_en;
        logic [BUCKET_BITS-1:0] wr_addr;
        logic [LINK_W-1:0]      wr_head;
    } bucket_req_t;

    // Entry store write control
    typedef struct packed {
        logic                    wr_en;
        logic [IDX_W-1:0]        addr;
        logic [LINK_W-1:0]       next;
        logic [KEY_W-1:0]        key;
        logic [PAYLOAD_BITS-1:0] payload;
    } entry_wr_t;

endpackage

`default_nettype wire

@@ design/chj_bucket_store.sv @@
// ----------------------------------------------------------------------------
// chj_bucket_store: bucket head memory
// One head link per bucket with a valid bit per bucket; an invalid bucket
// reads as the end-of-chain marker. Clear drops all valid bits at once.
// ----------------------------------------------------------------------------
`default_nettype none

module chj_bucket_store
    import chj_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire bucket_req_t            req,
    input  wire logic [BUCKET_BITS-1:0] rd_addr,
    output logic      [LINK_W-1:0]      rd_head
);

    logic [LINK_W-1:0]   head_mem [NBUCKETS];
    logic [NBUCKETS-1:0] valid_reg;
    logic [LINK_W-1:0]   rdata_reg;
    logic                rvalid_reg;

    // Track which buckets hold a live head
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (req.clear) begin
            valid_reg <= '0;
        end else if (req.wr_en) begin
            valid_reg[req.wr_addr] <= 1'b1;
        end
    end

    // Write and registered read of the head links
    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            head_mem[req.wr_addr] <= req.wr_head;
        end
        rdata_reg  <= head_mem[rd_addr];
        rvalid_reg <= valid_reg[rd_addr];
    end

    assign rd_head = rvalid_reg ? rdata_reg : END_MARK;

endmodule

`default_nettype wire

@@ design/chj_entry_store.sv @@
// ----------------------------------------------------------------------------
// chj_entry_store: build entry memory
// Holds next link, key and payload for every entry, one write port and one
// registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module chj_entry_store
    import chj_pkg::*;
(
    input  wire logic                    aclk,
    input  wire entry_wr_t               wr,
    input  wire logic [IDX_W-1:0]        rd_addr,
    output logic      [LINK_W-1:0]       rd_next,
    output logic      [KEY_W-1:0]        rd_key,
    output logic      [PAYLOAD_BITS-1:0] rd_payload
);

    logic [LINK_W-1:0]       next_mem [CAPACITY];
    logic [KEY_W-1:0]        key_mem  [CAPACITY];
    logic [PAYLOAD_BITS-1:0] pay_mem  [CAPACITY];

    // Write one entry, read one entry per cycle
    always_ff @(posedge aclk) begin
        if (wr.wr_en) begin
            next_mem[wr.addr] <= wr.next;
            key_mem[wr.addr]  <= wr.key;
            pay_mem[wr.addr]  <= wr.payload;
        end
        rd_next    <= next_mem[rd_addr];
        rd_key     <= key_mem[rd_addr];
        rd_payload <= pay_mem[rd_addr];
    end

endmodule

`default_nettype wire

@@ design/chained_hash_join_table.sv @@
// ----------------------------------------------------------------------------
// chained_hash_join_table: chained hash-join build and probe table
// Clear, insert and probe requests are run by a small sequencer over a
// bucket head memory and an entry memory; probe walks the chain one entry
// at a time through a single key comparator.
//
//   channel   ports              direction   payload
//   request   s_valid/s_ready    in          chj_in_t  (opcode, key, payload)
//   result    m_valid/m_ready    out         chj_out_t (status, match_payload,
//                                                       match_key, last)
//
// Each probe chain step is a read of the entry memory (S_WALK) then a key
// compare (S_ENTRY). Opcode 3 is accepted and gives no result.
// Reset is synchronous and active low; it empties the table at once, with no
// clearing pass. A result held in the output register by a low m_ready
// stalls the sequencer only when the next result must be written.
// ----------------------------------------------------------------------------
`default_nettype none

module chained_hash_join_table
    import chj_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire chj_in_t  s_data,
    output logic          m_valid,
    input  wire logic     m_ready,
    output chj_out_t      m_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR,
        S_LOOKUP,
        S_HEAD,
        S_WALK,
        S_ENTRY,
        S_FINISH
    } state_t;

    state_t                  state_reg, state_next;
    chj_in_t                 req_reg, req_next;
    logic [LINK_W-1:0]       count_reg, count_next;
    logic [LINK_W-1:0]       cur_reg, cur_next;
    logic [LINK_W-1:0]       steps_reg, steps_next;
    logic                    pend_valid_reg, pend_valid_next;
    logic [KEY_W-1:0]        pend_key_reg, pend_key_next;
    logic [PAYLOAD_BITS-1:0] pend_pay_reg, pend_pay_next;
    logic                    m_valid_reg, m_valid_next;
    chj_out_t                m_data_reg, m_data_next;

    bucket_req_t             bucket_req;
    entry_wr_t               entry_wr;
    logic [LINK_W-1:0]       head;
    logic [LINK_W-1:0]       ent_next;
    logic [KEY_W-1:0]        ent_key;
    logic [PAYLOAD_BITS-1:0] ent_pay;

    logic                    out_free;
    logic                    emit;
    chj_out_t                emit_data;
    logic                    key_hit;
    logic                    in_chain;

    chj_bucket_store u_bucket (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (bucket_req),
        .rd_addr (req_reg.key[BUCKET_BITS-1:0]),
        .rd_head (head)
    );

    chj_entry_store u_entry (
        .aclk       (aclk),
        .wr         (entry_wr),
        .rd_addr    (cur_reg[IDX_W-1:0]),
        .rd_next    (ent_next),
        .rd_key     (ent_key),
        .rd_payload (ent_pay)
    );

    assign out_free = !m_valid_reg || m_ready;
    assign key_hit  = (ent_key == req_reg.key);
    assign in_chain = (cur_reg < count_reg) && (steps_reg < CAP_LINK);

    // Sequence one request at a time
    always_comb begin
        state_next      = state_reg;
        req_next        = req_reg;
        count_next      = count_reg;
        cur_next        = cur_reg;
        steps_next      = steps_reg;
        pend_valid_next = pend_valid_reg;
        pend_key_next   = pend_key_reg;
        pend_pay_next   = pend_pay_reg;
        bucket_req      = '0;
        entry_wr        = '0;
        emit            = 1'b0;
        emit_data       = '0;
        emit_data.last  = 1'b1;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    req_next = s_data;
                    case (s_data.opcode)
                        OP_CLEAR:  state_next = S_CLEAR;
                        OP_INSERT: state_next = S_LOOKUP;
                        OP_PROBE:  state_next = S_LOOKUP;
                        default:   state_next = S_IDLE;
                    endcase
                end
            end
            S_CLEAR: begin
                if (out_free) begin
                    bucket_req.clear = 1'b1;
                    count_next       = '0;
                    emit             = 1'b1;
                    emit_data.status = ST_CLEARED;
                    state_next       = S_IDLE;
                end
            end
            S_LOOKUP: begin
                state_next = S_HEAD;
            end
            S_HEAD: begin
                if (req_reg.opcode == OP_INSERT) begin
                    if (out_free) begin
                        emit       = 1'b1;
                        state_next = S_IDLE;
                        if (count_reg >= CAP_LINK) begin
                            emit_data.status = ST_FULL;
                        end else begin
                            emit_data.status   = ST_INSERTED;
                            entry_wr.wr_en     = 1'b1;
                            entry_wr.addr      = count_reg[IDX_W-1:0];
                            entry_wr.next      = head;
                            entry_wr.key       = req_reg.key;
                            entry_wr.payload   = req_reg.payload[PAYLOAD_BITS-1:0];
                            bucket_req.wr_en   = 1'b1;
                            bucket_req.wr_addr = req_reg.key[BUCKET_BITS-1:0];
                            bucket_req.wr_head = count_reg;
                            count_next         = count_reg + 1'b1;
                        end
                    end
                end else begin
                    cur_next        = head;
                    steps_next      = '0;
                    pend_valid_next = 1'b0;
                    state_next      = S_WALK;
                end
            end
            S_WALK: begin
                // Entry read goes out at cur_reg this cycle
                state_next = in_chain ? S_ENTRY : S_FINISH;
            end
            S_ENTRY: begin
                // Hold while a new hit must push out an earlier match and the output register is full
                if (!(key_hit && pend_valid_reg && !out_free)) begin
                    if (key_hit) begin
                        if (pend_valid_reg) begin
                            emit                    = 1'b1;
                            emit_data.status        = ST_MATCH;
                            emit_data.match_key     = pend_key_reg;
                            emit_data.match_payload = OUT_PAY_W'(pend_pay_reg);
                            emit_data.last          = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_key_next   = ent_key;
                        pend_pay_next   = ent_pay;
                    end
                    cur_next   = ent_next;
                    steps_next = steps_reg + 1'b1;
                    state_next = S_WALK;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    emit = 1'b1;
                    if (pend_valid_reg) begin
                        emit_data.status        = ST_MATCH;
                        emit_data.match_key     = pend_key_reg;
                        emit_data.match_payload = OUT_PAY_W'(pend_pay_reg);
                    end else begin
                        emit_data.status = ST_NOMATCH;
                    end
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Load the output register on emit, drop it once taken
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (emit) begin
            m_valid_next = 1'b1;
            m_data_next  = emit_data;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // Hold state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
        req_reg      <= req_next;
        cur_reg      <= cur_next;
        steps_reg    <= steps_next;
        pend_key_reg <= pend_key_next;
        pend_pay_reg <= pend_pay_next;
        m_data_reg   <= m_data_next;
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

@@ dv/tb_chained_hash_join_table.sv @@
// ----------------------------------------------------------------------------
// tb_chained_hash_join_table: self-checking testbench for the hash-join table
// Drives clear, insert, probe and unused-opcode requests with bursty valid timing against
// a stalling result receiver, predicts every result with a table model of
// its own, and checks each accepted result field by field in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_chained_hash_join_table;
    import chj_pkg::*;

    localparam int ITEMS_TOTAL  = 470;
    localparam int DRAIN_CYCLES = 300;
    localparam int IDLE_LIMIT   = 4000;

    localparam logic [1:0]          OP_UNUSED   = 2'd3;
    localparam logic [KEY_W-1:0]    BUCKET_MASK = KEY_W'(NBUCKETS - 1);
    localparam logic [IN_PAY_W-1:0] PAY_MASK    =
        {IN_PAY_W{1'b1}} >> (IN_PAY_W - PAYLOAD_BITS);

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    chj_in_t  s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    chj_out_t m_data;

    chained_hash_join_table dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Free-running clock, period 20
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Table model state
    logic [LINK_W-1:0]    tbl_heads [NBUCKETS];
    logic [LINK_W-1:0]    tbl_next  [CAPACITY];
    logic [KEY_W-1:0]     tbl_key   [CAPACITY];
    logic [OUT_PAY_W-1:0] tbl_pay   [CAPACITY];
    int                   tbl_count;

    chj_out_t join_results_q [$];

    // Run statistics
    int n_errors     = 0;
    int n_items      = 0;
    int n_ignored    = 0;
    int n_checked    = 0;
    int n_match      = 0;
    int n_nomatch    = 0;
    int n_full       = 0;
    int n_inserted   = 0;
    int n_cleared    = 0;
    int max_hits     = 0;
    int burst_left   = 0;

    // ------------------------------------------------------------------------
    // Table model: apply one request and queue the results it causes
    // ------------------------------------------------------------------------
    function automatic chj_out_t make_result(status_t st, logic [OUT_PAY_W-1:0] pay,
                                             logic [KEY_W-1:0] key, logic lst);
        chj_out_t r;
        r.status        = st;
        r.match_payload = pay;
        r.match_key     = key;
        r.last          = lst;
        return r;
    endfunction

    // Append one expected result at the tail
    task automatic queue_result(input chj_out_t r);
        join_results_q.insert(join_results_q.size(), r);
    endtask

    task automatic predict_join(input chj_in_t req);
        int                   n_hits;
        int                   b;
        int                   cur;
        int                   steps;
        b = int'(req.key & BUCKET_MASK);
        case (req.opcode)
            OP_CLEAR: begin
                for (int i = 0; i < NBUCKETS; i++) tbl_heads[i] = END_MARK;
                tbl_count = 0;
                queue_result(make_result(ST_CLEARED, '0, '0, 1'b1));
            end
            OP_INSERT: begin
                if (tbl_count >= CAPACITY) begin
                    queue_result(make_result(ST_FULL, '0, '0, 1'b1));
                end else begin
                    tbl_key[tbl_count]  = req.key;
                    tbl_pay[tbl_count]  = OUT_PAY_W'(req.payload & PAY_MASK);
                    tbl_next[tbl_count] = tbl_heads[b];
                    tbl_heads[b]        = LINK_W'(tbl_count);
                    tbl_count++;
                    queue_result(make_result(ST_INSERTED, '0, '0, 1'b1));
                end
            end
            OP_PROBE: begin
                // Walk newest to oldest; stop at the end mark or a stale link
                cur    = int'(tbl_heads[b]);
                steps  = 0;
                n_hits = 0;
                while (cur != int'(END_MARK) && cur < tbl_count && cur < CAPACITY &&
                       steps < CAPACITY) begin
                    if (tbl_key[cur] == req.key) begin
                        queue_result(make_result(ST_MATCH, tbl_pay[cur], tbl_key[cur], 1'b0));
                        n_hits++;
                    end
                    cur = int'(tbl_next[cur]);
                    steps++;
                end
                if (n_hits == 0) begin
                    queue_result(make_result(ST_NOMATCH, '0, '0, 1'b1));
                end else begin
                    if (n_hits > max_hits) max_hits = n_hits;
                    join_results_q[join_results_q.size() - 1].last = 1'b1;
                end
            end
            default: begin
                // Unused opcode: no state change, no result
            end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Sender: bursts of back-to-back requests with random gaps between them
    // ------------------------------------------------------------------------
    function automatic chj_in_t make_req(logic [1:0] op, logic [KEY_W-1:0] key,
                                         logic [IN_PAY_W-1:0] pay);
        chj_in_t r;
        r.opcode  = opcode_t'(op);
        r.key     = key;
        r.payload = pay;
        return r;
    endfunction

    function automatic logic [IN_PAY_W-1:0] rand_pay();
        return {$urandom, $urandom};
    endfunction

    task automatic send_req(input chj_in_t req);
        int gap;
        // Between bursts, insert a random idle gap, which may be empty
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) == 0)
                gap = 0;
            else if ($urandom_range(0, 7) == 0)
                gap = $urandom_range(8, 20);
            else
                gap = $urandom_range(1, 3);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
        burst_left--;
        if (req.opcode == OP_UNUSED) n_ignored++;
        else n_items++;
        predict_join(req);
    endtask

    // ------------------------------------------------------------------------
    // Receiver and result check
    // ------------------------------------------------------------------------
    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $display("%0t ERROR %s: expected %h, actual %h", $time, name, want, got);
            n_errors++;
        end
    endtask

    task automatic check_result(input chj_out_t got);
        chj_out_t want;
        if (join_results_q.size() == 0) begin
            $display("%0t ERROR unexpected result: expected none, actual %h", $time, got);
            n_errors++;
        end else begin
            want = join_results_q.pop_front();
            n_checked++;
            check_field("status", 64'(want.status), 64'(got.status));
            check_field("match_payload", 64'(want.match_payload), 64'(got.match_payload));
            check_field("match_key", 64'(want.match_key), 64'(got.match_key));
            check_field("last", 64'(want.last), 64'(got.last));
            case (want.status)
                ST_MATCH:    n_match++;
                ST_NOMATCH:  n_nomatch++;
                ST_FULL:     n_full++;
                ST_INSERTED: n_inserted++;
                default:     n_cleared++;
            endcase
        end
    endtask

    int rx_mode    = 0;
    int phase_left = 0;
    int hold_left  = 0;

    // Check accepted results, then pick m_ready from the current stall mode
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) check_result(m_data);
            if (phase_left == 0) begin
                rx_mode    = $urandom_range(0, 2);
                phase_left = $urandom_range(32, 256);
            end else begin
                phase_left--;
            end
            case (rx_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= ($urandom_range(0, 9) < 7);
                default: begin
                    if (hold_left != 0) begin
                        hold_left--;
                        m_ready <= 1'b0;
                    end else begin
                        m_ready <= 1'b1;
                        if ($urandom_range(0, 7) == 0) hold_left = $urandom_range(1, 16);
                    end
                end
            endcase
        end
    end

    // Watchdog: end the run if nothing moves on either channel for too long
    int idle_cycles = 0;
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t ERROR timeout: no handshake for %0d cycles, %0d results pending",
                     $time, IDLE_LIMIT, join_results_q.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Probe the table straight out of reset
    task automatic test_empty_probe();
        send_req(make_req(OP_PROBE, '0, rand_pay()));
        send_req(make_req(OP_PROBE, '1, rand_pay()));
    endtask

    // Extreme keys and payloads, bucket collisions, probe hits and misses
    task automatic test_insert_probe();
        send_req(make_req(OP_CLEAR, '1, '1));
        send_req(make_req(OP_INSERT, 32'h0000_0000, 64'h0));
        send_req(make_req(OP_INSERT, 32'hFFFF_FFFF, '1));
        send_req(make_req(OP_INSERT, 32'h0000_0040, 64'h5555_5555_5555_5555));
        send_req(make_req(OP_INSERT, 32'hAAAA_AAAA, 64'hAAAA_AAAA_AAAA_AAAA));
        send_req(make_req(OP_PROBE, 32'h0000_0000, '1));
        send_req(make_req(OP_PROBE, 32'hFFFF_FFFF, '0));
        send_req(make_req(OP_PROBE, 32'h0000_0040, rand_pay()));
        send_req(make_req(OP_PROBE, 32'h0000_0080, rand_pay()));
        send_req(make_req(OP_PROBE, 32'h0000_0001, rand_pay()));
    endtask

    // Repeated key: several results newest first, last only on the final one
    task automatic test_duplicate_keys();
        logic [KEY_W-1:0] k;
        k = $urandom;
        repeat (3) send_req(make_req(OP_INSERT, k, rand_pay()));
        send_req(make_req(OP_PROBE, k, rand_pay()));
    endtask

    // Unused opcode leaves the table alone
    task automatic test_unused_opcode();
        send_req(make_req(OP_UNUSED, 32'h0000_0000, '0));
        send_req(make_req(OP_UNUSED, 32'h0000_0040, '1));
        send_req(make_req(OP_PROBE, 32'h0000_0040, rand_pay()));
    endtask

    // Clear drops every entry
    task automatic test_clear();
        send_req(make_req(OP_CLEAR, $urandom, rand_pay()));
        send_req(make_req(OP_PROBE, 32'hFFFF_FFFF, rand_pay()));
    endtask

    // Fill with one key, refuse further inserts, probe the full chain
    task automatic test_table_full();
        logic [KEY_W-1:0] k;
        k = $urandom;
        send_req(make_req(OP_CLEAR, $urandom, rand_pay()));
        repeat (CAPACITY) send_req(make_req(OP_INSERT, k, rand_pay()));
        send_req(make_req(OP_INSERT, $urandom, rand_pay()));
        send_req(make_req(OP_UNUSED, $urandom, rand_pay()));
        send_req(make_req(OP_INSERT, k, rand_pay()));
        send_req(make_req(OP_PROBE, k, rand_pay()));
        send_req(make_req(OP_PROBE, (~k & ~BUCKET_MASK) | (k & BUCKET_MASK), rand_pay()));
        send_req(make_req(OP_CLEAR, $urandom, rand_pay()));
        send_req(make_req(OP_INSERT, k, rand_pay()));
        send_req(make_req(OP_PROBE, k, rand_pay()));
    endtask

    // Build/probe sessions over small key pools with forced bucket collisions
    task automatic test_random_sessions();
        logic [KEY_W-1:0] pool [8];
        logic [KEY_W-1:0] k;
        int               pool_n;
        int               n_ops;
        int               pick;
        while (n_items < ITEMS_TOTAL) begin
            // Skip the clear now and then so the table can fill up
            if ($urandom_range(0, 4) != 0)
                send_req(make_req(OP_CLEAR, $urandom, rand_pay()));
            pool_n = $urandom_range(1, 8);
            for (int i = 0; i < pool_n; i++) begin
                pool[i] = $urandom;
                if (i > 0 && $urandom_range(0, 1) == 1)
                    pool[i] = (pool[i] & ~BUCKET_MASK) | (pool[0] & BUCKET_MASK);
            end
            n_ops = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60) : $urandom_range(4, 16);
            repeat (n_ops) begin
                pick = $urandom_range(0, 99);
                k    = pool[$urandom_range(0, pool_n - 1)];
                if (pick < 5)
                    send_req(make_req(OP_UNUSED, $urandom, rand_pay()));
                else if (pick < 50)
                    send_req(make_req(OP_INSERT, k, rand_pay()));
                else if (pick < 85)
                    send_req(make_req(OP_PROBE, k, rand_pay()));
                else if (pick < 93)
                    send_req(make_req(OP_PROBE, ($urandom & ~BUCKET_MASK) | (k & BUCKET_MASK),
                                      rand_pay()));
                else
                    send_req(make_req(OP_PROBE, $urandom, rand_pay()));
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        for (int i = 0; i < NBUCKETS; i++) tbl_heads[i] = END_MARK;
        for (int i = 0; i < CAPACITY; i++) begin
            tbl_next[i] = '0;
            tbl_key[i]  = '0;
            tbl_pay[i]  = '0;
        end
        tbl_count = 0;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_probe();
        test_insert_probe();
        test_duplicate_keys();
        test_unused_opcode();
        test_clear();
        test_table_full();
        test_random_sessions();

        // Drop valid, drain expected results, then watch for stray ones
        s_valid <= 1'b0;
        while (join_results_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Ran %0d requests plus %0d with the unused opcode; checked %0d results.",
                 n_items, n_ignored, n_checked);
        $display("Saw %0d matches, %0d misses, %0d refused inserts, %0d inserts, %0d clears; %s%0d",
                 n_match, n_nomatch, n_full, n_inserted, n_cleared,
                 "largest probe answer ", max_hits);
        if (n_errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

`default_nettype wire
